@@ rtl/core/sdtt_pkg.sv @@
// Package: widths, CORDIC table and shared structures for the sky texel lookup
`default_nettype none
package sdtt_pkg;
    localparam int DIR_BITS     = 16;
    localparam int COORD_BITS   = 13;
    localparam int SQ_BITS      = 2 * DIR_BITS + 1;
    localparam int RHO_BITS     = DIR_BITS + 1;
    localparam int CORDIC_STEPS = 16;
    localparam int PRESCALE     = 14;
    localparam int CX_BITS      = RHO_BITS + PRESCALE + 3;
    localparam int ANG_BITS     = 20;
    localparam int ANG_ONE      = 65536;
    localparam int PROD_BITS    = 17 + 12;
    localparam int NUM_BITS     = PROD_BITS + DIR_BITS;
    localparam int QUO_BITS     = 30;
    localparam int DEN_BITS     = RHO_BITS + 16;

    localparam logic [2:0] REG_TEX   = 3'd0;
    localparam logic [2:0] REG_CCOL  = 3'd1;
    localparam logic [2:0] REG_CROW  = 3'd2;
    localparam logic [2:0] REG_HRAD  = 3'd3;
    localparam logic [2:0] REG_BGRGB = 3'd4;

    typedef logic signed [ANG_BITS-1:0] t_ang;

    function automatic t_ang atan_entry(input int i);
        unique case (i)
            0: atan_entry = 20'sd32768;
            1: atan_entry = 20'sd19344;
            2: atan_entry = 20'sd10221;
            3: atan_entry = 20'sd5188;
            4: atan_entry = 20'sd2604;
            5: atan_entry = 20'sd1303;
            6: atan_entry = 20'sd652;
            7: atan_entry = 20'sd326;
            8: atan_entry = 20'sd163;
            9: atan_entry = 20'sd81;
            10: atan_entry = 20'sd41;
            11: atan_entry = 20'sd20;
            12: atan_entry = 20'sd10;
            13: atan_entry = 20'sd5;
            14: atan_entry = 20'sd3;
            default: atan_entry = 20'sd1;
        endcase
    endfunction

    typedef struct packed {
        logic                  bg;
        logic                  xneg;
        logic                  yneg;
        logic [DIR_BITS-1:0]   ax;
        logic [DIR_BITS-1:0]   ay;
    } t_side;
endpackage
`default_nettype wire

@@ rtl/core/sdtt_isqrt.sv @@
// Pipelined integer square root of x*x + y*y, one result bit per stage
`default_nettype none
module sdtt_isqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [sdtt_pkg::SQ_BITS-1:0]   i_val,
    output logic      [sdtt_pkg::RHO_BITS-1:0]  o_root
);
    localparam int N = sdtt_pkg::RHO_BITS;
    localparam int W = 2 * N;

    logic [W-1:0] r_rem  [N+1];
    logic [W-1:0] r_res  [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W'(i_val);
            r_res[0] <= '0;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - s));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[s] >= r_res[s] + BIT) begin
                    r_rem[s+1] <= r_rem[s] - (r_res[s] + BIT);
                    r_res[s+1] <= (r_res[s] >> 1) + BIT;
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_res[s+1] <= r_res[s] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[N][N-1:0];
endmodule
`default_nettype wire

@@ rtl/core/sdtt_cordic.sv @@
// Pipelined CORDIC vectoring for the zenith distance
`default_nettype none
module sdtt_cordic (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [sdtt_pkg::DIR_BITS-1:0]  i_z,
    input  wire logic [sdtt_pkg::RHO_BITS-1:0]  i_rho,
    output logic      [16:0]                    o_ang
);
    localparam int N = sdtt_pkg::CORDIC_STEPS;
    localparam int W = sdtt_pkg::CX_BITS;

    logic signed [W-1:0] r_cx [N+1];
    logic signed [W-1:0] r_cy [N+1];
    sdtt_pkg::t_ang      r_an [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= signed'(W'(i_z) << sdtt_pkg::PRESCALE);
            r_cy[0] <= signed'(W'(i_rho) << sdtt_pkg::PRESCALE);
            r_an[0] <= '0;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[s] > 0) begin
                    r_cx[s+1] <= r_cx[s] + (r_cy[s] >>> s);
                    r_cy[s+1] <= r_cy[s] - (r_cx[s] >>> s);
                    r_an[s+1] <= r_an[s] + sdtt_pkg::atan_entry(s);
                end else begin
                    r_cx[s+1] <= r_cx[s] - (r_cy[s] >>> s);
                    r_cy[s+1] <= r_cy[s] + (r_cx[s] >>> s);
                    r_an[s+1] <= r_an[s] - sdtt_pkg::atan_entry(s);
                end
            end
        end
    end

    always_comb begin
        if (r_an[N] < 0)
            o_ang = '0;
        else if (r_an[N] > sdtt_pkg::ANG_BITS'(sdtt_pkg::ANG_ONE))
            o_ang = 17'(sdtt_pkg::ANG_ONE);
        else
            o_ang = r_an[N][16:0];
    end
endmodule
`default_nettype wire

@@ rtl/core/sdtt_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module sdtt_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [sdtt_pkg::NUM_BITS-1:0]  i_num,
    input  wire logic [sdtt_pkg::DEN_BITS-1:0]  i_den,
    output logic      [sdtt_pkg::QUO_BITS-1:0]  o_quo
);
    localparam int N  = sdtt_pkg::QUO_BITS;
    localparam int NB = sdtt_pkg::NUM_BITS;
    localparam int DB = sdtt_pkg::DEN_BITS;
    localparam int RW = DB + 1;

    logic [RW-1:0] r_rem [N+1];
    logic [N-1:0]  r_num [N+1];
    logic [DB-1:0] r_den [N+1];
    logic [N-1:0]  r_quo [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num[NB-1:N]);
            r_num[0] <= i_num[N-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [RW-1:0] w_t;
        assign w_t = {r_rem[s][RW-2:0], r_num[s][N-1-s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                if (w_t >= RW'(r_den[s])) begin
                    r_rem[s+1] <= w_t - RW'(r_den[s]);
                    r_quo[s+1] <= {r_quo[s][N-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_t;
                    r_quo[s+1] <= {r_quo[s][N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[N];
endmodule
`default_nettype wire

@@ rtl/core/sky_direction_to_texel.sv @@
// Top level: direction to fisheye sky texel lookup pipeline
// Usage:
//   s_axis carries one ray direction per item; tdata = dir_x, dir_y, dir_z
//   (16 bits each, from bit 0). m_axis returns one result per item:
//   tdata = texel_col, texel_row, color_out; tuser = is_background.
//   Write registers through i_cfg_we / i_cfg_idx / i_cfg_data while idle:
//   0 texture_enabled, 1 center_col, 2 center_row, 3 horizon_radius,
//   4 background_rgb; other indexes are ignored.
//   Throughput: one item per cycle while the output is not stalled. Items pass
//   through the input register, squares, square root, CORDIC, multiply,
//   the one-bit-per-stage divider (30 stages plus its input register) and
//   the output register.
//   The whole pipeline advances only when the output register is free or
//   taken, so a stall holds every item in place and loses nothing.
//   Reset clears the configuration registers and all valid bits.
`default_nettype none
module sky_direction_to_texel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // dir_x, dir_y, dir_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // texel_col, texel_row, color_out, pad
    output logic             m_axis_tuser,   // is_background
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);
    localparam int DB  = sdtt_pkg::DIR_BITS;

    logic        r_tex;
    logic [11:0] r_ccol, r_crow, r_hrad;
    logic [23:0] r_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex <= 1'b0; r_ccol <= '0; r_crow <= '0; r_hrad <= '0; r_bg <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sdtt_pkg::REG_TEX)   r_tex  <= i_cfg_data[0];
            if (i_cfg_idx == sdtt_pkg::REG_CCOL)  r_ccol <= i_cfg_data[11:0];
            if (i_cfg_idx == sdtt_pkg::REG_CROW)  r_crow <= i_cfg_data[11:0];
            if (i_cfg_idx == sdtt_pkg::REG_HRAD)  r_hrad <= i_cfg_data[11:0];
            if (i_cfg_idx == sdtt_pkg::REG_BGRGB) r_bg   <= i_cfg_data;
        end
    end

    logic w_adv;
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    logic signed [DB-1:0] w_x, w_y, w_z;
    assign w_x = signed'(s_axis_tdata[DB-1:0]);
    assign w_y = signed'(s_axis_tdata[2*DB-1:DB]);
    assign w_z = signed'(s_axis_tdata[3*DB-1:2*DB]);

    logic [DB-1:0] r_ax, r_ay, r_z;
    logic          r_v0;
    sdtt_pkg::t_side r_s0;
    logic [sdtt_pkg::SQ_BITS-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (w_adv) r_v0 <= s_axis_tvalid;
        if (w_adv) begin
            r_ax <= w_x[DB-1] ? DB'(-w_x) : DB'(w_x);
            r_ay <= w_y[DB-1] ? DB'(-w_y) : DB'(w_y);
            r_z  <= DB'(w_z);
            r_s0.bg   <= !r_tex || w_z[DB-1];
            r_s0.xneg <= w_x[DB-1];
            r_s0.yneg <= w_y[DB-1];
            r_s0.ax   <= w_x[DB-1] ? DB'(-w_x) : DB'(w_x);
            r_s0.ay   <= w_y[DB-1] ? DB'(-w_y) : DB'(w_y);
        end
    end

    // squares registered ahead of the root
    logic [DB-1:0] r_z1;
    logic          r_v1;
    sdtt_pkg::t_side r_s1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= r_v0;
        if (w_adv) begin
            r_sq <= sdtt_pkg::SQ_BITS'(r_ax * r_ax) + sdtt_pkg::SQ_BITS'(r_ay * r_ay);
            r_z1 <= r_z;
            r_s1 <= r_s0;
        end
    end

    logic [sdtt_pkg::RHO_BITS-1:0] w_rho;
    sdtt_isqrt u_sqrt (.i_clk(i_clk), .i_en(w_adv), .i_val(r_sq), .o_root(w_rho));

    localparam int D1 = sdtt_pkg::RHO_BITS + 1;
    logic [DB-1:0]   r_zd [D1];
    sdtt_pkg::t_side r_sd [D1];
    logic [D1-1:0]   r_vd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= '0;
        else if (w_adv) r_vd <= {r_vd[D1-2:0], r_v1};
        if (w_adv) begin
            r_zd[0] <= r_z1; r_sd[0] <= r_s1;
            for (int k = 1; k < D1; k++) begin
                r_zd[k] <= r_zd[k-1]; r_sd[k] <= r_sd[k-1];
            end
        end
    end

    logic [16:0] w_ang;
    sdtt_cordic u_cordic (.i_clk(i_clk), .i_en(w_adv), .i_z(r_zd[D1-1]),
                          .i_rho(w_rho), .o_ang(w_ang));

    // rho travels beside the CORDIC
    localparam int D2 = sdtt_pkg::CORDIC_STEPS + 1;
    logic [sdtt_pkg::RHO_BITS-1:0] r_rd [D2];
    sdtt_pkg::t_side               r_sc [D2];
    logic [D2-1:0]                 r_vc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= '0;
        else if (w_adv) r_vc <= {r_vc[D2-2:0], r_vd[D1-1]};
        if (w_adv) begin
            r_rd[0] <= w_rho; r_sc[0] <= r_sd[D1-1];
            for (int k = 1; k < D2; k++) begin
                r_rd[k] <= r_rd[k-1]; r_sc[k] <= r_sc[k-1];
            end
        end
    end

    logic [sdtt_pkg::PROD_BITS-1:0] r_p;
    logic [sdtt_pkg::NUM_BITS-1:0]  r_nc, r_nr;
    logic [sdtt_pkg::RHO_BITS-1:0]  r_m1r, r_m2r;
    sdtt_pkg::t_side                r_m1s, r_m2s;
    logic                           r_m1v, r_m2v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0; r_m2v <= 1'b0;
        end else if (w_adv) begin
            r_m1v <= r_vc[D2-1]; r_m2v <= r_m1v;
        end
        if (w_adv) begin
            r_p   <= sdtt_pkg::PROD_BITS'(w_ang * r_hrad);
            r_m1r <= r_rd[D2-1]; r_m1s <= r_sc[D2-1];
            r_nc  <= sdtt_pkg::NUM_BITS'(r_p * r_m1s.ax);
            r_nr  <= sdtt_pkg::NUM_BITS'(r_p * r_m1s.ay);
            r_m2r <= r_m1r; r_m2s <= r_m1s;
        end
    end

    logic [sdtt_pkg::DEN_BITS-1:0] w_den;
    assign w_den = (r_m2r == '0) ? sdtt_pkg::DEN_BITS'(1)
                                 : {r_m2r, 16'd0};
    logic [sdtt_pkg::QUO_BITS-1:0] w_qc, w_qr;
    sdtt_divider u_divc (.i_clk(i_clk), .i_en(w_adv), .i_num(r_nc), .i_den(w_den),
                         .o_quo(w_qc));
    sdtt_divider u_divr (.i_clk(i_clk), .i_en(w_adv), .i_num(r_nr), .i_den(w_den),
                         .o_quo(w_qr));

    // zero rho means a zero numerator, so the quotient is zero anyway
    localparam int D3 = sdtt_pkg::QUO_BITS + 1;
    sdtt_pkg::t_side r_sq3 [D3];
    logic [D3-1:0]   r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= '0;
        else if (w_adv) r_v3 <= {r_v3[D3-2:0], r_m2v};
        if (w_adv) begin
            r_sq3[0] <= r_m2s;
            for (int k = 1; k < D3; k++) r_sq3[k] <= r_sq3[k-1];
        end
    end

    localparam int CB = sdtt_pkg::COORD_BITS;
    logic [CB-1:0] w_cm, w_rm, w_col, w_row;
    sdtt_pkg::t_side w_sf;
    assign w_sf  = r_sq3[D3-1];
    assign w_cm  = w_qc[CB-1:0];
    assign w_rm  = w_qr[CB-1:0];
    assign w_col = w_sf.xneg ? CB'(r_ccol) - w_cm : CB'(r_ccol) + w_cm;
    assign w_row = w_sf.yneg ? CB'(r_crow) + w_rm : CB'(r_crow) - w_rm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (w_adv) m_axis_tvalid <= r_v3[D3-1];
        if (w_adv) begin
            m_axis_tuser <= w_sf.bg;
            m_axis_tdata <= w_sf.bg ? {6'd0, r_bg, 26'd0}
                                    : {30'd0, w_row, w_col};
        end
    end

    logic w_unused;
    assign w_unused = ^{w_qc[sdtt_pkg::QUO_BITS-1:CB], w_qr[sdtt_pkg::QUO_BITS-1:CB]};
endmodule
`default_nettype wire

@@ tb/tb_sky_direction_to_texel.sv @@
// Testbench for the sky direction to texel lookup: random and directed rays
`default_nettype none

class texel_scoreboard;
    typedef struct packed {
        logic        bg;
        logic [12:0] col;
        logic [12:0] row;
        logic [23:0] rgb;
    } t_texel;

    logic        tex_en;
    logic [11:0] ctr_col;
    logic [11:0] ctr_row;
    logic [11:0] hor_rad;
    logic [23:0] bg_rgb;
    t_texel      pending[$];
    int          errors;

    function new();
        tex_en = 0; ctr_col = 0; ctr_row = 0; hor_rad = 0; bg_rgb = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            sdtt_pkg::REG_TEX:   tex_en = val[0];
            sdtt_pkg::REG_CCOL:  ctr_col = val[11:0];
            sdtt_pkg::REG_CROW:  ctr_row = val[11:0];
            sdtt_pkg::REG_HRAD:  hor_rad = val[11:0];
            sdtt_pkg::REG_BGRGB: bg_rgb = val;
            default: ;
        endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    static function longint unsigned zenith_dist(longint unsigned a, longint unsigned b);
        longint cx, cy, ang, dx, dy;
        longint tab[16] = '{32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
                            163, 81, 41, 20, 10, 5, 3, 1};
        cx = a << 14;
        cy = b << 14;
        ang = 0;
        for (int i = 0; i < 16; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx += dx; cy -= dy; ang += tab[i];
            end else begin
                cx -= dx; cy += dy; ang -= tab[i];
            end
        end
        if (ang < 0) ang = 0;
        if (ang > 65536) ang = 65536;
        return ang;
    endfunction

    function void note_ray(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
        t_texel t;
        longint unsigned ax, ay, rho, ang, den, cmag, rmag;
        longint col, row;
        t = '0;
        if (!tex_en || z < 0) begin
            t.bg = 1;
            t.rgb = bg_rgb;
        end else begin
            ax = (x < 0) ? -longint'(x) : longint'(x);
            ay = (y < 0) ? -longint'(y) : longint'(y);
            rho = int_sqrt(ax * ax + ay * ay);
            col = ctr_col;
            row = ctr_row;
            if (rho != 0) begin
                ang = zenith_dist(longint'(z), rho);
                den = rho << 16;
                cmag = (ang * hor_rad * ax) / den;
                rmag = (ang * hor_rad * ay) / den;
                col += (x < 0) ? -longint'(cmag) : longint'(cmag);
                row -= (y < 0) ? -longint'(rmag) : longint'(rmag);
            end
            t.col = col[12:0];
            t.row = row[12:0];
        end
        pending.push_back(t);
    endfunction

    function void check_texel(logic bg, logic [55:0] data);
        t_texel e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result bg=%0b data=%h", $time, bg, data);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (bg !== e.bg) begin
            $display("%0t: is_background expected %0b actual %0b", $time, e.bg, bg);
            errors++;
        end
        if (data[12:0] !== e.col) begin
            $display("%0t: texel_col expected %0d actual %0d", $time, e.col, data[12:0]);
            errors++;
        end
        if (data[25:13] !== e.row) begin
            $display("%0t: texel_row expected %0d actual %0d", $time, e.row, data[25:13]);
            errors++;
        end
        if (data[49:26] !== e.rgb) begin
            $display("%0t: color_out expected %h actual %h", $time, e.rgb, data[49:26]);
            errors++;
        end
    endfunction
endclass

module tb_sky_direction_to_texel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 70;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // dir_x, dir_y, dir_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;        // texel_col, texel_row, color_out, pad
    logic        m_axis_tuser;        // is_background
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    texel_scoreboard sb = new();
    bit long_hold = 0;

    sky_direction_to_texel dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_texel(m_axis_tuser, m_axis_tdata);
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (long_hold)
            m_axis_tready <= 0;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0) || ($time / 20000 % 2 == 0);
    end

    task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 0;
    endtask

    task automatic send_ray(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        if ($urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_ray(x, y, z);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [15:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: begin x = 16'($urandom); y = 16'($urandom); z = 16'($urandom); end
                1: begin
                    x = 16'($urandom); y = 16'($urandom);
                    z = 16'($urandom_range(0, 32767));
                end
                2: begin
                    x = 16'($urandom_range(0, 15) - 8); y = 16'($urandom_range(0, 15) - 8);
                    z = 16'($urandom_range(0, 32767));
                end
                3: begin
                    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom_range(0, 3));
                end
                default: begin
                    x = {16{1'($urandom_range(0, 1))}} ^ 16'($urandom_range(0, 32767));
                    y = 16'($urandom); z = 16'($urandom_range(16384, 32767));
                end
            endcase
            send_ray(x, y, z);
        end
    endtask

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // texture off: background everywhere
        write_cfg(sdtt_pkg::REG_BGRGB, 24'hFFFFFF);
        send_ray(16'h1234, 16'h0000, 16'h7FFF);
        send_ray(16'h8000, 16'h8000, 16'h8000);
        go_idle();

        write_cfg(sdtt_pkg::REG_TEX, 24'h1);
        write_cfg(sdtt_pkg::REG_CCOL, 24'd2048);
        write_cfg(sdtt_pkg::REG_CROW, 24'd2048);
        write_cfg(sdtt_pkg::REG_HRAD, 24'd2048);
        write_cfg(sdtt_pkg::REG_BGRGB, 24'h5A3C96);
        write_cfg(REG_UNUSED, 24'hFFFFFF);
        send_ray(16'h0000, 16'h0000, 16'h0000);
        send_ray(16'h0000, 16'h0000, 16'h7FFF);
        send_ray(16'h7FFF, 16'h0000, 16'h0000);
        send_ray(16'h8000, 16'h0000, 16'h0000);
        send_ray(16'h0000, 16'h7FFF, 16'h0000);
        send_ray(16'h0000, 16'h8000, 16'h0000);
        send_ray(16'h8000, 16'h8000, 16'h0000);
        send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_ray(16'h8000, 16'h7FFF, 16'h0001);
        send_ray(16'h0001, 16'hFFFF, 16'h7FFF);
        send_ray(16'h1000, 16'h1000, 16'hFFFF);
        send_ray(16'h8000, 16'h8000, 16'h8000);
        go_idle();

        write_cfg(sdtt_pkg::REG_CCOL, 24'd4095);
        write_cfg(sdtt_pkg::REG_CROW, 24'd0);
        write_cfg(sdtt_pkg::REG_HRAD, 24'd4095);
        random_phase(150);
        // hold the receiver off while items keep coming
        long_hold = 1;
        fork
            random_phase(150);
            begin
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end
        join
        go_idle();

        write_cfg(sdtt_pkg::REG_CCOL, 24'd0);
        write_cfg(sdtt_pkg::REG_CROW, 24'd4095);
        write_cfg(sdtt_pkg::REG_HRAD, 24'd0);
        write_cfg(sdtt_pkg::REG_BGRGB, 24'h000000);
        random_phase(100);
        go_idle();

        write_cfg(sdtt_pkg::REG_CCOL, 24'd1000);
        write_cfg(sdtt_pkg::REG_CROW, 24'd700);
        write_cfg(sdtt_pkg::REG_HRAD, 24'd700);
        random_phase(150);
        go_idle();

        write_cfg(sdtt_pkg::REG_TEX, 24'h0);
        write_cfg(sdtt_pkg::REG_BGRGB, 24'hA5C35A);
        random_phase(30);
        go_idle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/sdtt_pkg.sv
rtl/core/sdtt_isqrt.sv
rtl/core/sdtt_cordic.sv
rtl/core/sdtt_divider.sv
rtl/core/sky_direction_to_texel.sv
tb/tb_sky_direction_to_texel.sv
